/* src/bsei_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the B-spline exposure interpolator.
// Used by bsei_setup, bsei_blend, the top level and the checker.
package bsei_pkg;

    localparam int KNOT_REGS        = 6;
    localparam int MAX_IMAGES_DEF   = 6;
    localparam int SAMPLE_BITS_DEF  = 20;
    localparam int BISECT_STEPS_DEF = 16;

    localparam int TIME_W     = 16;
    localparam int IDX_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WGT_W      = 17;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

    // floor(x / 6) == (x * RECIP6) >> RECIP_SHIFT for x < 2^19
    localparam logic signed [21:0] RECIP6      = 22'sd349526;
    localparam int                 RECIP_SHIFT = 21;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_QUERY_TIME  = 3'd0,
        CFG_IMAGE_COUNT = 3'd1,
        CFG_KNOT_0      = 3'd2,
        CFG_KNOT_1      = 3'd3,
        CFG_KNOT_2      = 3'd4,
        CFG_KNOT_3      = 3'd5,
        CFG_KNOT_4      = 3'd6,
        CFG_KNOT_5      = 3'd7
    } t_cfg_reg;

    typedef logic [IDX_W-1:0] t_img_idx;

    typedef struct packed {
        t_img_idx [3:0]              idx;
        logic     [3:0][WGT_W-1:0]   weight;
        logic                        in_range;
    } t_blend_cfg;

    typedef enum logic [2:0] {
        ST_START,
        ST_SEARCH,
        ST_COEF,
        ST_BISECT,
        ST_WEIGHT,
        ST_DONE
    } t_setup_state;

    typedef enum logic [2:0] {
        PH_SQ,
        PH_CU,
        PH_A,
        PH_B,
        PH_C
    } t_bis_phase;

    typedef enum logic [2:0] {
        WP_T2,
        WP_T3,
        WP_U2,
        WP_U3,
        WP_W0,
        WP_W1,
        WP_W2,
        WP_W3
    } t_wgt_phase;

    // Limit a signed image index to 0 .. n-1
    function automatic t_img_idx clamp_index(input logic signed [4:0] v,
                                             input logic [IDX_W-1:0] n);
        logic signed [4:0] hi_lim;
        t_img_idx          r;
        hi_lim = $signed({2'b00, n}) - 5'sd1;
        if (v < 5'sd0) begin
            r = '0;
        end else if (v > hi_lim) begin
            r = hi_lim[IDX_W-1:0];
        end else begin
            r = v[IDX_W-1:0];
        end
        return r;
    endfunction

    // Four images of segment s: clamp(s-2) .. clamp(s+1)
    function automatic logic [3:0][IDX_W-1:0] window_of(input logic [IDX_W-1:0] s,
                                                        input logic [IDX_W-1:0] n);
        logic signed [4:0]        sb;
        logic [3:0][IDX_W-1:0]    w;
        sb   = $signed({2'b00, s});
        w[0] = clamp_index(sb - 5'sd2, n);
        w[1] = clamp_index(sb - 5'sd1, n);
        w[2] = clamp_index(sb, n);
        w[3] = clamp_index(sb + 5'sd1, n);
        return w;
    endfunction

endpackage

/* src/bsei_setup.sv */
`timescale 1ns / 1ps
// Configuration registers and setup sequencer: segment search, bisection for t, basis weights.
// Depends on bsei_pkg. One shared 22x22 multiplier serves bisection and weight phases.
module bsei_setup #(
    parameter int MAX_IMAGES   = bsei_pkg::MAX_IMAGES_DEF,
    parameter int BISECT_STEPS = bsei_pkg::BISECT_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsei_pkg::CFG_ADDR_W-1:0]   i_cfg_idx,
    input  logic [bsei_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_busy,
    output bsei_pkg::t_blend_cfg              o_blend_cfg
);

    localparam int N_MAX  = (MAX_IMAGES < bsei_pkg::KNOT_REGS) ? MAX_IMAGES
                                                               : bsei_pkg::KNOT_REGS;
    localparam int STEP_W = $clog2(BISECT_STEPS);
    localparam int TW     = bsei_pkg::TIME_W;
    localparam int IW     = bsei_pkg::IDX_W;
    localparam int WW     = bsei_pkg::WGT_W;

    // configuration registers
    logic [TW-1:0] r_query;
    logic [IW-1:0] r_count;
    logic [TW-1:0] r_knot [bsei_pkg::KNOT_REGS];

    // sequencer state
    bsei_pkg::t_setup_state r_state, n_state;
    bsei_pkg::t_bis_phase   r_bph;
    bsei_pkg::t_wgt_phase   r_wph;
    logic                   r_done;
    logic [IW-1:0]          r_seg;
    logic [STEP_W-1:0]      r_step;
    logic [WW-1:0]          r_w [4];
    logic                   r_in_range;

    // working registers
    logic [TW-1:0]          r_win [4];
    logic signed [20:0]     r_coef_a, r_coef_b, r_coef_c, r_dq;
    logic [WW-1:0]          r_lo, r_hi, r_t2, r_t3, r_u2, r_u3;
    logic signed [41:0]     r_acc;

    logic [IW-1:0]          cnt_n, seg_last, rd_addr;
    logic [TW-1:0]          knot_rd, first_t, last_t;
    logic                   q_out, q_first, q_last, hit, last_step;
    logic [18:0]            q6, end6;
    logic [WW-1:0]          mid, u_val;
    logic signed [21:0]     mul_a, mul_b;
    logic signed [43:0]     mul_p;
    logic signed [41:0]     sum_c, dq_q16;
    logic                   below;
    logic signed [21:0]     t2s, t3s, num1, num2, div_in;
    logic signed [20:0]     k0s, k1s, k2s, k3s, qs;

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
            r_count <= IW'(2);
            for (int i = 0; i < bsei_pkg::KNOT_REGS; i++) begin
                r_knot[i] <= TW'(i);
            end
        end else if (i_cfg_we) begin
            unique case (bsei_pkg::t_cfg_reg'(i_cfg_idx))
                bsei_pkg::CFG_QUERY_TIME:  r_query <= i_cfg_data[TW-1:0];
                bsei_pkg::CFG_IMAGE_COUNT: r_count <= i_cfg_data[IW-1:0];
                default: r_knot[IW'(i_cfg_idx - bsei_pkg::CFG_KNOT_0)] <= i_cfg_data[TW-1:0];
            endcase
        end
    end

    // ---------------- shared decode ----------------
    always_comb begin
        if (r_count < IW'(2)) begin
            cnt_n = IW'(2);
        end else if (r_count > IW'(N_MAX)) begin
            cnt_n = IW'(N_MAX);
        end else begin
            cnt_n = r_count;
        end
    end

    assign seg_last = cnt_n + IW'(1);
    // addressed read port into the knot registers; knots 0 and 1 are also read directly
    assign rd_addr  = (r_state == bsei_pkg::ST_START) ? (cnt_n - IW'(1))
                    : bsei_pkg::clamp_index($signed({2'b00, r_seg}) + 5'sd2, cnt_n);
    assign knot_rd  = r_knot[rd_addr];
    assign first_t  = r_knot[0];
    assign last_t   = knot_rd;

    assign q_out   = (r_query < first_t) || (r_query > last_t);
    assign q_first = (r_query == first_t);
    assign q_last  = (r_query == last_t);

    assign q6   = 19'(r_query) * 19'd6;
    assign end6 = 19'(r_win[1]) + {1'b0, r_win[2], 2'b00} + 19'(r_win[3]);
    assign hit  = (q6 <= end6);

    assign mid       = WW'((18'(r_lo) + 18'(r_hi)) >> 1);
    assign u_val     = bsei_pkg::ONE_Q16 - r_hi;
    assign last_step = (r_step == STEP_W'(BISECT_STEPS - 1));

    assign k0s = $signed({5'b0, r_win[0]});
    assign k1s = $signed({5'b0, r_win[1]});
    assign k2s = $signed({5'b0, r_win[2]});
    assign k3s = $signed({5'b0, r_win[3]});
    assign qs  = $signed({5'b0, r_query});

    assign t2s  = $signed({5'b0, r_t2});
    assign t3s  = $signed({5'b0, r_t3});
    assign num1 = 22'sd262144 - 22'sd6 * t2s + 22'sd3 * t3s;
    assign num2 = 22'sd65536 + 22'sd3 * $signed({5'b0, r_hi}) + 22'sd3 * t2s - 22'sd3 * t3s;

    always_comb begin
        case (r_wph)
            bsei_pkg::WP_W0: div_in = $signed({5'b0, r_u3});
            bsei_pkg::WP_W1: div_in = (num1 < 22'sd0) ? 22'sd0 : num1;
            bsei_pkg::WP_W2: div_in = (num2 < 22'sd0) ? 22'sd0 : num2;
            default:         div_in = t3s;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == bsei_pkg::ST_BISECT) begin
            case (r_bph)
                bsei_pkg::PH_SQ: begin
                    mul_a = $signed({5'b0, mid});
                    mul_b = $signed({5'b0, mid});
                end
                bsei_pkg::PH_CU: begin
                    mul_a = t2s;
                    mul_b = $signed({5'b0, mid});
                end
                bsei_pkg::PH_A: begin
                    mul_a = 22'(r_coef_a);
                    mul_b = t3s;
                end
                bsei_pkg::PH_B: begin
                    mul_a = 22'(r_coef_b);
                    mul_b = t2s;
                end
                default: begin
                    mul_a = 22'(r_coef_c);
                    mul_b = $signed({5'b0, mid});
                end
            endcase
        end else if (r_state == bsei_pkg::ST_WEIGHT) begin
            case (r_wph)
                bsei_pkg::WP_T2: begin
                    mul_a = $signed({5'b0, r_hi});
                    mul_b = $signed({5'b0, r_hi});
                end
                bsei_pkg::WP_T3: begin
                    mul_a = t2s;
                    mul_b = $signed({5'b0, r_hi});
                end
                bsei_pkg::WP_U2: begin
                    mul_a = $signed({5'b0, u_val});
                    mul_b = $signed({5'b0, u_val});
                end
                bsei_pkg::WP_U3: begin
                    mul_a = $signed({5'b0, r_u2});
                    mul_b = $signed({5'b0, u_val});
                end
                default: begin
                    mul_a = div_in + 22'sd3;
                    mul_b = bsei_pkg::RECIP6;
                end
            endcase
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign sum_c  = r_acc + 42'(mul_p);
    assign dq_q16 = {{5{r_dq[20]}}, r_dq, 16'b0};
    assign below  = (sum_c < dq_q16);

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsei_pkg::ST_START;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (n_state == bsei_pkg::ST_DONE);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsei_pkg::ST_START: begin
                if (q_out || q_first || q_last) begin
                    n_state = bsei_pkg::ST_DONE;
                end else begin
                    n_state = bsei_pkg::ST_SEARCH;
                end
            end
            bsei_pkg::ST_SEARCH: begin
                if ((r_seg == seg_last) || hit) begin
                    n_state = bsei_pkg::ST_COEF;
                end
            end
            bsei_pkg::ST_COEF: n_state = bsei_pkg::ST_BISECT;
            bsei_pkg::ST_BISECT: begin
                if ((r_bph == bsei_pkg::PH_C) && last_step) begin
                    n_state = bsei_pkg::ST_WEIGHT;
                end
            end
            bsei_pkg::ST_WEIGHT: begin
                if (r_wph == bsei_pkg::WP_W3) begin
                    n_state = bsei_pkg::ST_DONE;
                end
            end
            bsei_pkg::ST_DONE: n_state = bsei_pkg::ST_DONE;
            default: n_state = bsei_pkg::ST_START;
        endcase
        // any register write restarts the setup
        if (i_cfg_we) begin
            n_state = bsei_pkg::ST_START;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg      <= '0;
            r_step     <= '0;
            r_bph      <= bsei_pkg::PH_SQ;
            r_wph      <= bsei_pkg::WP_T2;
            r_in_range <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            case (r_state)
                bsei_pkg::ST_START: begin
                    r_seg      <= '0;
                    r_in_range <= !q_out;
                    for (int i = 0; i < 4; i++) begin
                        r_w[i] <= '0;
                    end
                    if (!q_out && q_first) begin
                        r_w[0] <= bsei_pkg::ONE_Q16;
                    end else if (!q_out && q_last) begin
                        r_seg  <= seg_last;
                        r_w[0] <= bsei_pkg::ONE_Q16;
                    end
                end
                bsei_pkg::ST_SEARCH: begin
                    if (!((r_seg == seg_last) || hit)) begin
                        r_seg <= r_seg + IW'(1);
                    end
                end
                bsei_pkg::ST_COEF: begin
                    r_step <= '0;
                    r_bph  <= bsei_pkg::PH_SQ;
                end
                bsei_pkg::ST_BISECT: begin
                    case (r_bph)
                        bsei_pkg::PH_SQ: r_bph <= bsei_pkg::PH_CU;
                        bsei_pkg::PH_CU: r_bph <= bsei_pkg::PH_A;
                        bsei_pkg::PH_A:  r_bph <= bsei_pkg::PH_B;
                        bsei_pkg::PH_B:  r_bph <= bsei_pkg::PH_C;
                        default: begin
                            r_bph  <= bsei_pkg::PH_SQ;
                            r_step <= r_step + STEP_W'(1);
                            r_wph  <= bsei_pkg::WP_T2;
                        end
                    endcase
                end
                bsei_pkg::ST_WEIGHT: begin
                    case (r_wph)
                        bsei_pkg::WP_T2: r_wph <= bsei_pkg::WP_T3;
                        bsei_pkg::WP_T3: r_wph <= bsei_pkg::WP_U2;
                        bsei_pkg::WP_U2: r_wph <= bsei_pkg::WP_U3;
                        bsei_pkg::WP_U3: r_wph <= bsei_pkg::WP_W0;
                        bsei_pkg::WP_W0: begin
                            r_w[0] <= mul_p[bsei_pkg::RECIP_SHIFT +: WW];
                            r_wph  <= bsei_pkg::WP_W1;
                        end
                        bsei_pkg::WP_W1: begin
                            r_w[1] <= mul_p[bsei_pkg::RECIP_SHIFT +: WW];
                            r_wph  <= bsei_pkg::WP_W2;
                        end
                        bsei_pkg::WP_W2: begin
                            r_w[2] <= mul_p[bsei_pkg::RECIP_SHIFT +: WW];
                            r_wph  <= bsei_pkg::WP_W3;
                        end
                        default: begin
                            r_w[3] <= mul_p[bsei_pkg::RECIP_SHIFT +: WW];
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            bsei_pkg::ST_START: begin
                // window of segment zero
                r_win[0] <= first_t;
                r_win[1] <= first_t;
                r_win[2] <= first_t;
                r_win[3] <= r_knot[1];
            end
            bsei_pkg::ST_SEARCH: begin
                if (!((r_seg == seg_last) || hit)) begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= r_win[3];
                    r_win[3] <= knot_rd;
                end
            end
            bsei_pkg::ST_COEF: begin
                r_coef_a <= k3s - k0s + 21'sd3 * (k1s - k2s);
                r_coef_b <= 21'sd3 * k0s - 21'sd6 * k1s + 21'sd3 * k2s;
                r_coef_c <= 21'sd3 * (k2s - k0s);
                r_dq     <= 21'sd6 * qs - (k0s + 21'sd4 * k1s + k2s);
                r_lo     <= '0;
                r_hi     <= bsei_pkg::ONE_Q16;
            end
            bsei_pkg::ST_BISECT: begin
                case (r_bph)
                    bsei_pkg::PH_SQ: r_t2  <= mul_p[16 +: WW];
                    bsei_pkg::PH_CU: r_t3  <= mul_p[16 +: WW];
                    bsei_pkg::PH_A:  r_acc <= 42'(mul_p);
                    bsei_pkg::PH_B:  r_acc <= sum_c;
                    default: begin
                        if (below) begin
                            r_lo <= mid;
                        end else begin
                            r_hi <= mid;
                        end
                    end
                endcase
            end
            bsei_pkg::ST_WEIGHT: begin
                case (r_wph)
                    bsei_pkg::WP_T2: r_t2 <= mul_p[16 +: WW];
                    bsei_pkg::WP_T3: r_t3 <= mul_p[16 +: WW];
                    bsei_pkg::WP_U2: r_u2 <= mul_p[16 +: WW];
                    bsei_pkg::WP_U3: r_u3 <= mul_p[16 +: WW];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_busy = !r_done;

    always_comb begin
        o_blend_cfg.idx      = bsei_pkg::window_of(r_seg, cnt_n);
        o_blend_cfg.in_range = r_in_range;
        for (int i = 0; i < 4; i++) begin
            o_blend_cfg.weight[i] = r_w[i];
        end
    end

endmodule

/* src/bsei_blend.sv */
`timescale 1ns / 1ps
// Per-pixel blend pipeline: sample select, four weight products, round and saturate.
// Depends on bsei_pkg for the blend configuration struct.
module bsei_blend #(
    parameter int SAMPLE_BITS = bsei_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_accept,
    input  logic [bsei_pkg::KNOT_REGS-1:0][SAMPLE_BITS-1:0]   i_samples,
    input  bsei_pkg::t_blend_cfg                              i_blend_cfg,
    output logic                                              o_valid,
    output logic [SAMPLE_BITS-1:0]                            o_blended_sample,
    output logic                                              o_query_in_range
);

    localparam int PROD_W = SAMPLE_BITS + bsei_pkg::WGT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHR_W  = ACC_W - 16;

    logic                   r_s1_vld, r_s2_vld;
    logic [SAMPLE_BITS-1:0] r_s1_smp [4];
    logic [PROD_W-1:0]      r_s2_prod [4];
    logic [ACC_W-1:0]       sum_r;
    logic [SHR_W-1:0]       sum_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
            r_s2_vld <= r_s1_vld;
            o_valid  <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_s1_smp[i]  <= i_samples[i_blend_cfg.idx[i]];
            r_s2_prod[i] <= PROD_W'(r_s1_smp[i]) * PROD_W'(i_blend_cfg.weight[i]);
        end
    end

    // round half up, then clip to the sample range
    assign sum_r   = ACC_W'(r_s2_prod[0]) + ACC_W'(r_s2_prod[1]) + ACC_W'(r_s2_prod[2])
                   + ACC_W'(r_s2_prod[3]) + ACC_W'(32768);
    assign sum_shr = sum_r[ACC_W-1:16];

    always_ff @(posedge i_clk) begin
        if (|sum_shr[SHR_W-1:SAMPLE_BITS]) begin
            o_blended_sample <= '1;
        end else begin
            o_blended_sample <= sum_shr[SAMPLE_BITS-1:0];
        end
        o_query_in_range <= i_blend_cfg.in_range;
    end

endmodule

/* src/bspline_exposure_pixel_interpolator.sv */
`timescale 1ns / 1ps
// Top level of the cubic B-spline exposure interpolator: config/setup unit plus blend pipeline.
// Depends on bsei_pkg, bsei_setup and bsei_blend.
//
// After reset and after every configuration write the block spends a setup run with busy
// high: a range check, a segment search, a coefficient step, bisection for t and the weight
// phases, with bisection and weights sharing one multiplier; a query outside the knot span
// or on an end knot goes straight from the range check to done. Once busy is low, a pixel
// word is taken on every cycle that start is high, and its result appears with o_valid after
// the registered sample select, four parallel weight products, then sum, round and saturate.
// Results cannot be held off; capture them on the cycle o_valid is high.
module bspline_exposure_pixel_interpolator #(
    parameter int MAX_IMAGES   = bsei_pkg::MAX_IMAGES_DEF,
    parameter int SAMPLE_BITS  = bsei_pkg::SAMPLE_BITS_DEF,
    parameter int BISECT_STEPS = bsei_pkg::BISECT_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [SAMPLE_BITS-1:0]            i_sample_0,
    input  logic [SAMPLE_BITS-1:0]            i_sample_1,
    input  logic [SAMPLE_BITS-1:0]            i_sample_2,
    input  logic [SAMPLE_BITS-1:0]            i_sample_3,
    input  logic [SAMPLE_BITS-1:0]            i_sample_4,
    input  logic [SAMPLE_BITS-1:0]            i_sample_5,
    output logic                              o_valid,
    output logic [SAMPLE_BITS-1:0]            o_blended_sample,
    output logic                              o_query_in_range,
    input  logic                              i_cfg_we,
    input  logic [bsei_pkg::CFG_ADDR_W-1:0]   i_cfg_idx,
    input  logic [bsei_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    bsei_pkg::t_blend_cfg                              blend_cfg;
    logic [bsei_pkg::KNOT_REGS-1:0][SAMPLE_BITS-1:0]   samples;
    logic                                              accept;

    assign samples = {i_sample_5, i_sample_4, i_sample_3, i_sample_2, i_sample_1, i_sample_0};
    assign accept  = start && !busy;

    bsei_setup #(
        .MAX_IMAGES   (MAX_IMAGES),
        .BISECT_STEPS (BISECT_STEPS)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_blend_cfg (blend_cfg)
    );

    bsei_blend #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_blend (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_samples        (samples),
        .i_blend_cfg      (blend_cfg),
        .o_valid          (o_valid),
        .o_blended_sample (o_blended_sample),
        .o_query_in_range (o_query_in_range)
    );

endmodule

/* src/bsei_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the B-spline exposure interpolator, bound to the top level.
// Depends on bsei_pkg for default parameter values.
module bsei_checker #(
    parameter int SAMPLE_BITS = bsei_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic [SAMPLE_BITS-1:0] o_blended_sample,
    input logic                   o_query_in_range,
    input logic                   i_cfg_we
);

    // every accepted word comes out as a result with o_valid
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted word did not produce a result after three cycles");

    // no result without a matching earlier accepted word
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result word without a matching accepted word");

    // query outside the knot span blends to zero
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_query_in_range) |-> (o_blended_sample == '0))
        else $error("out-of-range query gave a nonzero result");

    // a register write always triggers a new setup run
    a_write_starts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("busy not raised after configuration write");

endmodule

bind bspline_exposure_pixel_interpolator bsei_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bsei_checker (.*);
